>>> rtl/ole_pkg.sv
// ole_pkg: sizes, request and status codes and sequencer states of the ordered list engine
// no dependencies; ole_if, ordered_list_engine and ole_checker import it
package ole_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int TOTAL_W  = 5;

    localparam logic [REQ_W-1:0] REQ_FRONT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_HEAD_WR,
        S_RESP
    } state_t;

endpackage

>>> rtl/ole_if.sv
// ole_req_if and ole_rsp_if: valid/ready channels of the ordered list engine
// depends on ole_pkg
interface ole_req_if
    import ole_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface ole_rsp_if
    import ole_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [TOTAL_W-1:0]  entry_total;

    modport source (output valid, output status, output position, output entry_total,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_total,
                    output ready);
endinterface

>>> rtl/ole_ram.sv
// ole_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/ordered_list_engine.sv
// ordered_list_engine: ordered list of signed words kept packed in one ram
// depends on ole_pkg, ole_if (ole_req_if, ole_rsp_if) and ole_ram
//
//   channel | dir | payload                          | note
//   req     | in  | req_type, value                  | taken only while the sequencer idles
//   rsp     | out | status, position, entry_total    | one item per request, output register
//
// sequencing: insert back, clear, full or empty cases go straight to the response
// register; search reads and compares entries from the head until a hit or the tail;
// insert front moves each entry up one place from the tail, then writes the head; delete
// scans to the hit, then moves each later entry down one place. the single ram read port
// sets the pace: each entry's registered read is compared or written back in the next cycle.
// reset clears the count and the control; the ram needs no clearing pass since only
// entries below the count are read.
// a stalled response holds in the output register while the next request is taken.
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ole_req_if.sink     req,
    ole_rsp_if.source   rsp
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [REQ_W-1:0]    op_reg, op_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;

    // response output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;

    // ram port signals
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic [CNT_W-1:0]    idx_minus;
    logic [CNT_W-1:0]    idx_plus;
    logic                list_full;
    logic                req_take;
    logic                out_free;

    assign idx_minus = idx_reg - CNT_W'(1);
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign list_full = (count_reg == CNT_W'(CAPACITY));
    assign req.ready = (state_reg == S_IDLE);
    assign req_take  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // list storage; reads and writes never touch the same entry in neighboring cycles
    ole_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            op_reg        <= REQ_FRONT;
            status_reg    <= ST_DONE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            status_reg    <= status_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_total_reg  <= out_total_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_total_next  = out_total_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    op_next     = req.req_type;
                    key_next    = unsigned'(req.value);
                    status_next = ST_DONE;
                    pos_next    = '0;
                    idx_next    = '0;
                    state_next  = S_RESP;
                    unique case (req.req_type)
                        REQ_FRONT:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = unsigned'(req.value);
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                // walk from the tail down, moving each entry up one place
                                idx_next   = count_reg;
                                state_next = S_MOVE_RD;
                            end
                        end
                        REQ_BACK:
                        begin
                            if (list_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = unsigned'(req.value);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE, REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unknown request: list untouched, plain done
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[IDX_W-1:0];
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    if (op_reg == REQ_SEARCH)
                    begin
                        pos_next   = idx_reg[IDX_W-1:0];
                        state_next = S_RESP;
                    end
                    else if (idx_plus == count_reg)
                    begin
                        // hit on the last entry: nothing to close up
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_MOVE_RD;
                    end
                end
                else if (idx_plus == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    idx_next   = idx_plus;
                    state_next = S_SCAN_RD;
                end
            end
            S_MOVE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = (op_reg == REQ_FRONT) ? idx_minus[IDX_W-1:0]
                                                   : idx_plus[IDX_W-1:0];
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rd_data;
                if (op_reg == REQ_FRONT)
                begin
                    idx_next   = idx_minus;
                    state_next = (idx_reg == CNT_W'(1)) ? S_HEAD_WR : S_MOVE_RD;
                end
                else if (idx_plus + CNT_W'(1) == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_plus;
                    state_next = S_MOVE_RD;
                end
            end
            S_HEAD_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // wait here only while an earlier response is still unclaimed
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pos_next    = POS_W'(pos_reg);
                    out_total_next  = TOTAL_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.entry_total = out_total_reg;

endmodule

>>> rtl/ole_checker.sv
// ole_checker: port-level assertions for ordered_list_engine, attached by bind
// depends on ole_pkg and ordered_list_engine
module ole_checker
    import ole_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [POS_W-1:0]    rsp_position,
    input logic [TOTAL_W-1:0]  rsp_entry_total
);

    // a stalled response keeps its item
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_position) && $stable(rsp_entry_total))
        else $error("response changed while stalled");

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // refused and failed requests report position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL)
            |-> rsp_position == '0)
        else $error("nonzero position on failed request");

    // a full refusal reports the whole capacity
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_entry_total == TOTAL_W'(CAPACITY))
        else $error("full status without full count");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_position    (rsp.position),
    .rsp_entry_total (rsp.entry_total)
);
